[rtl/core/nqpt_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the queue pair tracker.
package nqpt_pkg;

    localparam int MAX_DEPTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

    localparam int CFG_DEPTH_W  = 11;
    localparam int CFG_QID_W    = 16;
    localparam int CFG_STRIDE_W = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;

    localparam int DB_OFFSET_W = 35;
    localparam logic [DB_OFFSET_W-1:0] DB_BASE = 35'h1000;
    localparam logic [15:0] STATUS_BUSY = 16'hFFFF;

    localparam logic [CFG_DEPTH_W-1:0] DEPTH_RESET = CFG_DEPTH_W'(MAX_DEPTH);

    // command codes carried by s_cmd; the unused code behaves as a query
    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_CQE    = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QID    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIDE = 2'd2;

    typedef enum logic [2:0] {
        OUT_SUBMITTED = 3'd0,
        OUT_FULL      = 3'd1,
        OUT_CONSUMED  = 3'd2,
        OUT_STALE     = 3'd3,
        OUT_DONE      = 3'd4,
        OUT_NOT_DONE  = 3'd5
    } outcome_t;

    typedef struct packed {
        logic capture;
        logic clear_en;
        logic mod_start;
        logic mod_sel_tail;
        logic load_cid;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_submit;
        logic full;
        logic clear_last;
        logic mod_done;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/core/nvme_queue_pair_tracker_top.sv]
// Top level of the NVMe queue pair tracker: controller, datapath and configuration port.
//
// Host-side bookkeeping for one submission/completion ring pair. After reset the block
// clears its 1024 tracker entries, one per cycle, and takes no word until that pass ends;
// configuration writes are taken at any time, cfg_ready is always high, but must only be
// issued while the block is idle. Items are handled one at a time.
// A completion entry or a query passes through the registered tracker memory read and then
// the commit cycle. An accepted submit has its new command id and tail each reduced modulo
// the ring depth by an 11-step bit-serial remainder unit. A submit refused as full skips the
// remainder unit. A result word waiting on m_ready holds the block in its commit cycle.
module nvme_queue_pair_tracker_top
    import nqpt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_cmd,
    input  logic [15:0]            s_cqe_cid,
    input  logic [15:0]            s_cqe_status,
    input  logic [31:0]            s_cqe_result,
    input  logic [15:0]            s_query_cid,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_outcome,
    output logic [ADDR_W-1:0]      m_assigned_cid,
    output logic [ADDR_W-1:0]      m_sq_slot,
    output logic                   m_matched,
    output logic                   m_doorbell_write,
    output logic [DB_OFFSET_W-1:0] m_doorbell_offset,
    output logic [ADDR_W-1:0]      m_doorbell_value,
    output logic [15:0]            m_cpl_status,
    output logic [31:0]            m_cpl_result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    nqpt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    nqpt_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_cmd             (s_cmd),
        .s_cqe_cid         (s_cqe_cid),
        .s_cqe_status      (s_cqe_status),
        .s_cqe_result      (s_cqe_result),
        .s_query_cid       (s_query_cid),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_outcome         (m_outcome),
        .m_assigned_cid    (m_assigned_cid),
        .m_sq_slot         (m_sq_slot),
        .m_matched         (m_matched),
        .m_doorbell_write  (m_doorbell_write),
        .m_doorbell_offset (m_doorbell_offset),
        .m_doorbell_value  (m_doorbell_value),
        .m_cpl_status      (m_cpl_status),
        .m_cpl_result      (m_cpl_result),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

[rtl/core/nqpt_mod_unit.sv]
// Bit-serial remainder unit: dividend modulo ring depth, one quotient bit per cycle.
module nqpt_mod_unit
    import nqpt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start_i,
    input  logic [DEPTH_W-1:0] dividend_i,
    input  logic [DEPTH_W-1:0] divisor_i,
    output logic               done_o,
    output logic [DEPTH_W-1:0] rem_o
);

    localparam int CNT_W = $clog2(DEPTH_W + 1);

    logic [DEPTH_W-1:0] div_reg, div_next;
    logic [DEPTH_W-1:0] dvd_reg, dvd_next;
    logic [DEPTH_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DEPTH_W-1:0] trial;

    // remainder stays below the divisor, so its top bit is free to shift out
    assign trial = {rem_reg[DEPTH_W-2:0], dvd_reg[DEPTH_W-1]};

    always_comb begin
        div_next   = div_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start_i) begin
            div_next   = divisor_i;
            dvd_next   = dividend_i;
            rem_next   = '0;
            count_next = CNT_W'(DEPTH_W);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_next   = (trial >= div_reg) ? (trial - div_reg) : trial;
            dvd_next   = {dvd_reg[DEPTH_W-2:0], 1'b0};
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        div_reg <= div_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done_o = done_reg;
    assign rem_o  = rem_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (rem_reg < div_reg))
        else $error("remainder not reduced below divisor");

endmodule

[rtl/core/nqpt_datapath.sv]
// Queue pair datapath: ring pointers, tracker memories, doorbell maths and result register.
module nqpt_datapath
    import nqpt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]             s_cmd,
    input  logic [15:0]            s_cqe_cid,
    input  logic [15:0]            s_cqe_status,
    input  logic [31:0]            s_cqe_result,
    input  logic [15:0]            s_query_cid,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [2:0]             m_outcome,
    output logic [ADDR_W-1:0]      m_assigned_cid,
    output logic [ADDR_W-1:0]      m_sq_slot,
    output logic                   m_matched,
    output logic                   m_doorbell_write,
    output logic [DB_OFFSET_W-1:0] m_doorbell_offset,
    output logic [ADDR_W-1:0]      m_doorbell_value,
    output logic [15:0]            m_cpl_status,
    output logic [31:0]            m_cpl_result,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status
);

    typedef struct packed {
        logic        busy;
        logic [15:0] stat;
    } meta_t;

    function automatic logic [DB_OFFSET_W-1:0] db_offset(input logic [16:0] slot,
                                                         input logic [3:0] stride_exp);
        logic [4:0] shamt;
        shamt = 5'(stride_exp) + 5'd2;
        return (DB_OFFSET_W'(slot) << shamt) + DB_BASE;
    endfunction

    // configuration
    logic [CFG_DEPTH_W-1:0]  qdepth_reg;
    logic [CFG_QID_W-1:0]    qid_reg;
    logic [CFG_STRIDE_W-1:0] stride_reg;
    logic [DEPTH_W-1:0]      depth_eff;

    // captured word
    logic [1:0]  cmd_reg;
    logic [15:0] cqe_cid_reg;
    logic [15:0] cqe_status_reg;
    logic [31:0] cqe_result_reg;
    logic [15:0] query_cid_reg;

    // queue state
    logic [ADDR_W-1:0]  sq_tail_reg, sq_tail_next;
    logic [ADDR_W-1:0]  cq_head_reg, cq_head_next;
    logic               phase_reg, phase_next;
    logic [ADDR_W-1:0]  next_cid_reg, next_cid_next;
    logic [DEPTH_W-1:0] in_flight_reg, in_flight_next;
    logic               pending_reg, pending_next;
    logic [ADDR_W-1:0]  cid_reg;
    logic [ADDR_W-1:0]  clr_reg;

    // tracker storage
    meta_t       meta_mem [MAX_DEPTH];
    logic [31:0] res_mem  [MAX_DEPTH];
    meta_t       meta_rd_reg;
    logic [31:0] res_rd_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic        meta_we;
    logic        res_we;
    meta_t       meta_wdata;

    // remainder unit
    logic [DEPTH_W-1:0] mod_operand;
    logic [DEPTH_W-1:0] mod_rem;
    logic               mod_done;

    // result register
    logic                   m_valid_reg, m_valid_next;
    logic [2:0]             outcome_reg, outcome_next;
    logic [ADDR_W-1:0]      acid_reg, acid_next;
    logic [ADDR_W-1:0]      slot_reg, slot_next;
    logic                   matched_reg, matched_next;
    logic                   dbw_reg, dbw_next;
    logic [DB_OFFSET_W-1:0] dbo_reg, dbo_next;
    logic [ADDR_W-1:0]      dbv_reg, dbv_next;
    logic [15:0]            cst_reg, cst_next;
    logic [31:0]            cres_reg, cres_next;

    logic full;
    logic cqe_hit;
    logic [ADDR_W-1:0] new_tail;

    always_comb begin
        if (qdepth_reg < CFG_DEPTH_W'(2)) begin
            depth_eff = DEPTH_W'(2);
        end else if (qdepth_reg > CFG_DEPTH_W'(MAX_DEPTH)) begin
            depth_eff = DEPTH_W'(MAX_DEPTH);
        end else begin
            depth_eff = DEPTH_W'(qdepth_reg);
        end
    end

    assign full     = in_flight_reg >= (depth_eff - 1'b1);
    assign rd_addr  = (cmd_reg == CMD_CQE) ? cqe_cid_reg[ADDR_W-1:0]
                                           : query_cid_reg[ADDR_W-1:0];
    assign cqe_hit  = (cqe_cid_reg < 16'(depth_eff)) && meta_rd_reg.busy;
    assign new_tail = mod_rem[ADDR_W-1:0];

    assign mod_operand = cmd.mod_sel_tail ? (DEPTH_W'(sq_tail_reg) + 1'b1)
                                          : DEPTH_W'(next_cid_reg);

    nqpt_mod_unit u_mod (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (cmd.mod_start),
        .dividend_i (mod_operand),
        .divisor_i  (depth_eff),
        .done_o     (mod_done),
        .rem_o      (mod_rem)
    );

    always_comb begin
        sq_tail_next   = sq_tail_reg;
        cq_head_next   = cq_head_reg;
        phase_next     = phase_reg;
        next_cid_next  = next_cid_reg;
        in_flight_next = in_flight_reg;
        pending_next   = pending_reg;
        meta_we        = 1'b0;
        res_we         = 1'b0;
        wr_addr        = rd_addr;
        meta_wdata     = '0;
        m_valid_next   = m_valid_reg & ~m_ready;
        outcome_next   = outcome_reg;
        acid_next      = acid_reg;
        slot_next      = slot_reg;
        matched_next   = matched_reg;
        dbw_next       = dbw_reg;
        dbo_next       = dbo_reg;
        dbv_next       = dbv_reg;
        cst_next       = cst_reg;
        cres_next      = cres_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
            acid_next    = '0;
            slot_next    = '0;
            matched_next = 1'b0;
            dbw_next     = 1'b0;
            dbo_next     = '0;
            dbv_next     = '0;
            cst_next     = '0;
            cres_next    = '0;
            case (cmd_reg)
                CMD_SUBMIT: begin
                    if (full) begin
                        outcome_next = OUT_FULL;
                    end else begin
                        outcome_next = OUT_SUBMITTED;
                        acid_next    = cid_reg;
                        slot_next    = sq_tail_reg;
                        if ((DEPTH_W'(cid_reg) + 1'b1) >= depth_eff) begin
                            next_cid_next = '0;
                        end else begin
                            next_cid_next = cid_reg + 1'b1;
                        end
                        sq_tail_next    = new_tail;
                        in_flight_next  = in_flight_reg + 1'b1;
                        wr_addr         = cid_reg;
                        meta_we         = 1'b1;
                        meta_wdata.busy = 1'b1;
                        meta_wdata.stat = STATUS_BUSY;
                        dbw_next        = 1'b1;
                        dbo_next        = db_offset({qid_reg, 1'b0}, stride_reg);
                        dbv_next        = new_tail;
                    end
                end
                CMD_CQE: begin
                    if (cqe_status_reg[0] != phase_reg) begin
                        // stale entry closes the poll; ring the head only if it moved
                        outcome_next = OUT_STALE;
                        if (pending_reg) begin
                            dbw_next = 1'b1;
                            dbo_next = db_offset({qid_reg, 1'b1}, stride_reg);
                            dbv_next = cq_head_reg;
                        end
                        pending_next = 1'b0;
                    end else begin
                        outcome_next = OUT_CONSUMED;
                        if (cqe_hit) begin
                            meta_we         = 1'b1;
                            res_we          = 1'b1;
                            meta_wdata.busy = 1'b0;
                            meta_wdata.stat = {1'b0, cqe_status_reg[15:1]};
                            matched_next    = 1'b1;
                            if (in_flight_reg != '0) begin
                                in_flight_next = in_flight_reg - 1'b1;
                            end
                        end
                        if ((DEPTH_W'(cq_head_reg) + 1'b1) >= depth_eff) begin
                            cq_head_next = '0;
                            phase_next   = ~phase_reg;
                        end else begin
                            cq_head_next = cq_head_reg + 1'b1;
                        end
                        pending_next = 1'b1;
                    end
                end
                default: begin
                    if ((query_cid_reg >= 16'(depth_eff)) || meta_rd_reg.busy ||
                        (meta_rd_reg.stat == STATUS_BUSY)) begin
                        outcome_next = OUT_NOT_DONE;
                    end else begin
                        outcome_next = OUT_DONE;
                        cst_next     = meta_rd_reg.stat;
                        cres_next    = res_rd_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qdepth_reg    <= DEPTH_RESET;
            qid_reg       <= '0;
            stride_reg    <= '0;
            sq_tail_reg   <= '0;
            cq_head_reg   <= '0;
            phase_reg     <= 1'b1;
            next_cid_reg  <= '0;
            in_flight_reg <= '0;
            pending_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            clr_reg       <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DEPTH:  qdepth_reg <= cfg_data[CFG_DEPTH_W-1:0];
                    CFG_QID:    qid_reg    <= cfg_data[CFG_QID_W-1:0];
                    CFG_STRIDE: stride_reg <= cfg_data[CFG_STRIDE_W-1:0];
                    default:    ;
                endcase
            end
            sq_tail_reg   <= sq_tail_next;
            cq_head_reg   <= cq_head_next;
            phase_reg     <= phase_next;
            next_cid_reg  <= next_cid_next;
            in_flight_reg <= in_flight_next;
            pending_reg   <= pending_next;
            m_valid_reg   <= m_valid_next;
            if (cmd.clear_en) begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
        if (cmd.capture) begin
            cmd_reg        <= s_cmd;
            cqe_cid_reg    <= s_cqe_cid;
            cqe_status_reg <= s_cqe_status;
            cqe_result_reg <= s_cqe_result;
            query_cid_reg  <= s_query_cid;
        end
        if (cmd.load_cid) begin
            cid_reg <= mod_rem[ADDR_W-1:0];
        end
        outcome_reg <= outcome_next;
        acid_reg    <= acid_next;
        slot_reg    <= slot_next;
        matched_reg <= matched_next;
        dbw_reg     <= dbw_next;
        dbo_reg     <= dbo_next;
        dbv_reg     <= dbv_next;
        cst_reg     <= cst_next;
        cres_reg    <= cres_next;
    end

    // tracker memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            meta_mem[clr_reg] <= '0;
            res_mem[clr_reg]  <= '0;
        end else begin
            if (meta_we) begin
                meta_mem[wr_addr] <= meta_wdata;
            end
            if (res_we) begin
                res_mem[wr_addr] <= cqe_result_reg;
            end
        end
        meta_rd_reg <= meta_mem[rd_addr];
        res_rd_reg  <= res_mem[rd_addr];
    end

    assign status.is_submit  = (cmd_reg == CMD_SUBMIT);
    assign status.full       = full;
    assign status.clear_last = (clr_reg == ADDR_W'(MAX_DEPTH - 1));
    assign status.mod_done   = mod_done;
    assign status.out_free   = ~m_valid_reg | m_ready;

    assign m_valid           = m_valid_reg;
    assign m_outcome         = outcome_reg;
    assign m_assigned_cid    = acid_reg;
    assign m_sq_slot         = slot_reg;
    assign m_matched         = matched_reg;
    assign m_doorbell_write  = dbw_reg;
    assign m_doorbell_offset = dbo_reg;
    assign m_doorbell_value  = dbv_reg;
    assign m_cpl_status      = cst_reg;
    assign m_cpl_result      = cres_reg;

    a_commit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result committed over an untaken word");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed result not presented");

    a_in_flight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight_reg < DEPTH_W'(MAX_DEPTH))
        else $error("in-flight count beyond ring capacity");

endmodule

[rtl/core/nqpt_ctrl.sv]
// Sequencing state machine: clearing pass, item dispatch, remainder steps and commit.
module nqpt_ctrl
    import nqpt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_CID_START,
        S_CID_WAIT,
        S_TAIL_START,
        S_TAIL_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.capture = s_valid & s_ready_reg;
                if (cmd.capture) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                // tracker read is issued here; a full ring needs no id
                if (status.is_submit && !status.full) begin
                    state_next = S_CID_START;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_CID_START: begin
                cmd.mod_start = 1'b1;
                state_next    = S_CID_WAIT;
            end
            S_CID_WAIT: begin
                cmd.load_cid = status.mod_done;
                if (status.mod_done) begin
                    state_next = S_TAIL_START;
                end
            end
            S_TAIL_START: begin
                cmd.mod_start    = 1'b1;
                cmd.mod_sel_tail = 1'b1;
                state_next       = S_TAIL_WAIT;
            end
            S_TAIL_WAIT: begin
                cmd.mod_sel_tail = 1'b1;
                if (status.mod_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.mod_sel_tail = 1'b1;
                cmd.commit       = status.out_free;
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        s_ready_next = (state_next == S_IDLE) && !cmd.capture;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

[bench/nvme_queue_pair_tracker_top_test.sv]
// Self-checking bench for the NVMe queue pair tracker: directed table, random polls, model check.
`timescale 1ns / 1ps

module nvme_queue_pair_tracker_top_test;
    import nqpt_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;    // unused code, behaves as a query

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] cqe_cid;
        logic [15:0] cqe_status;
        logic [31:0] cqe_result;
        logic [15:0] query_cid;
    } item_t;

    typedef struct packed {
        outcome_t               outcome;
        logic [ADDR_W-1:0]      assigned_cid;
        logic [ADDR_W-1:0]      sq_slot;
        logic                   matched;
        logic                   db_write;
        logic [DB_OFFSET_W-1:0] db_offset;
        logic [ADDR_W-1:0]      db_value;
        logic [15:0]            cpl_status;
        logic [31:0]            cpl_result;
    } result_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_DEPTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_cmd = CMD_SUBMIT;
    logic [15:0]            s_cqe_cid = '0;
    logic [15:0]            s_cqe_status = '0;
    logic [31:0]            s_cqe_result = '0;
    logic [15:0]            s_query_cid = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [2:0]             m_outcome;
    logic [ADDR_W-1:0]      m_assigned_cid;
    logic [ADDR_W-1:0]      m_sq_slot;
    logic                   m_matched;
    logic                   m_doorbell_write;
    logic [DB_OFFSET_W-1:0] m_doorbell_offset;
    logic [ADDR_W-1:0]      m_doorbell_value;
    logic [15:0]            m_cpl_status;
    logic [31:0]            m_cpl_result;

    nvme_queue_pair_tracker_top uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow registers and ring state of the tracker
    logic [CFG_DEPTH_W-1:0]  q_depth_reg;
    logic [CFG_QID_W-1:0]    q_id_reg;
    logic [CFG_STRIDE_W-1:0] q_stride_reg;
    logic [ADDR_W-1:0]       tail_m, head_m, cid_m;
    logic                    phase_m, ring_dirty_m;
    logic [DEPTH_W-1:0]      inflight_m;
    logic                    busy_m   [MAX_DEPTH];
    logic [15:0]             status_m [MAX_DEPTH];
    logic [31:0]             result_m [MAX_DEPTH];

    result_t awaited_words[$];
    row_t    plan[$];
    bit      row_typed = 1'b0;
    result_t row_want;
    int      mismatches = 0;
    int      items_sent = 0;
    int      burst_left = 0;

    int       ready_hold = 0;
    logic [7:0] ready_pat = 8'hFF;
    bit       ready_free = 1'b1;

    function automatic int eff_depth();
        int d;
        d = q_depth_reg;
        if (d < 2) d = 2;
        if (d > MAX_DEPTH) d = MAX_DEPTH;
        return d;
    endfunction

    function automatic logic [DB_OFFSET_W-1:0] bell_offset(input logic [16:0] slot);
        logic [63:0] stride;
        logic [63:0] off;
        stride = 64'd4 << q_stride_reg;
        off = 64'(DB_BASE) + 64'(slot) * stride;
        return off[DB_OFFSET_W-1:0];
    endfunction

    // next expected result word; updates the shadow ring state
    function automatic result_t track_item(input item_t it);
        result_t r;
        int depth;
        int cid;
        r = '0;
        depth = eff_depth();
        if (it.cmd == CMD_SUBMIT) begin
            if (int'(inflight_m) >= depth - 1) begin
                r.outcome = OUT_FULL;
            end else begin
                cid = int'(cid_m) % depth;
                cid_m = ADDR_W'((cid + 1) % depth);
                busy_m[cid] = 1'b1;
                status_m[cid] = STATUS_BUSY;
                r.outcome = OUT_SUBMITTED;
                r.assigned_cid = ADDR_W'(cid);
                r.sq_slot = tail_m;
                tail_m = ADDR_W'((int'(tail_m) + 1) % depth);
                inflight_m = inflight_m + 1'b1;
                r.db_write = 1'b1;
                r.db_offset = bell_offset({q_id_reg, 1'b0});
                r.db_value = tail_m;
            end
        end else if (it.cmd == CMD_CQE) begin
            if (it.cqe_status[0] != phase_m) begin
                r.outcome = OUT_STALE;
                if (ring_dirty_m) begin
                    r.db_write = 1'b1;
                    r.db_offset = bell_offset({q_id_reg, 1'b1});
                    r.db_value = head_m;
                end
                ring_dirty_m = 1'b0;
            end else begin
                r.outcome = OUT_CONSUMED;
                if (int'(it.cqe_cid) < depth && busy_m[it.cqe_cid[ADDR_W-1:0]]) begin
                    busy_m[it.cqe_cid[ADDR_W-1:0]] = 1'b0;
                    status_m[it.cqe_cid[ADDR_W-1:0]] = {1'b0, it.cqe_status[15:1]};
                    result_m[it.cqe_cid[ADDR_W-1:0]] = it.cqe_result;
                    if (inflight_m != 0) inflight_m = inflight_m - 1'b1;
                    r.matched = 1'b1;
                end
                if (int'(head_m) + 1 >= depth) begin
                    head_m = '0;
                    phase_m = ~phase_m;
                end else begin
                    head_m = head_m + 1'b1;
                end
                ring_dirty_m = 1'b1;
            end
        end else begin
            if (int'(it.query_cid) >= depth || busy_m[it.query_cid[ADDR_W-1:0]] ||
                status_m[it.query_cid[ADDR_W-1:0]] == STATUS_BUSY) begin
                r.outcome = OUT_NOT_DONE;
            end else begin
                r.outcome = OUT_DONE;
                r.cpl_status = status_m[it.query_cid[ADDR_W-1:0]];
                r.cpl_result = result_m[it.query_cid[ADDR_W-1:0]];
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        item_t   it;
        result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEPTH:  q_depth_reg  = cfg_data[CFG_DEPTH_W-1:0];
                    CFG_QID:    q_id_reg     = cfg_data[CFG_QID_W-1:0];
                    CFG_STRIDE: q_stride_reg = cfg_data[CFG_STRIDE_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                it = {s_cmd, s_cqe_cid, s_cqe_status, s_cqe_result, s_query_cid};
                want = track_item(it);
                awaited_words.push_back(row_typed ? row_want : want);
            end
            if (m_valid && m_ready) begin
                if (awaited_words.size() == 0) begin
                    note_mismatch("word with none awaited, outcome", m_outcome, 0);
                end else begin
                    want = awaited_words.pop_front();
                    if (m_outcome !== want.outcome)
                        note_mismatch("outcome", m_outcome, want.outcome);
                    if (m_assigned_cid !== want.assigned_cid)
                        note_mismatch("assigned_cid", m_assigned_cid, want.assigned_cid);
                    if (m_sq_slot !== want.sq_slot)
                        note_mismatch("sq_slot", m_sq_slot, want.sq_slot);
                    if (m_matched !== want.matched)
                        note_mismatch("matched", m_matched, want.matched);
                    if (m_doorbell_write !== want.db_write)
                        note_mismatch("doorbell_write", m_doorbell_write, want.db_write);
                    if (m_doorbell_offset !== want.db_offset)
                        note_mismatch("doorbell_offset", m_doorbell_offset, want.db_offset);
                    if (m_doorbell_value !== want.db_value)
                        note_mismatch("doorbell_value", m_doorbell_value, want.db_value);
                    if (m_cpl_status !== want.cpl_status)
                        note_mismatch("cpl_status", m_cpl_status, want.cpl_status);
                    if (m_cpl_result !== want.cpl_result)
                        note_mismatch("cpl_result", m_cpl_result, want.cpl_result);
                end
            end
        end
    end

    // receiver: rotating stall pattern, swapped now and then, sometimes free running
    always @(negedge aclk) begin
        if (ready_hold == 0) begin
            ready_hold = $urandom_range(20, 200);
            ready_pat = 8'($urandom_range(0, 255)) | 8'h01;
            ready_free = ($urandom_range(0, 3) == 0);
        end else begin
            ready_hold--;
        end
        ready_pat = {ready_pat[0], ready_pat[7:1]};
        m_ready <= ready_free | ready_pat[0];
    end

    function automatic item_t junk_item(input logic [1:0] cmd);
        item_t it;
        it.cmd = cmd;
        it.cqe_cid = 16'($urandom);
        it.cqe_status = 16'($urandom);
        it.cqe_result = $urandom;
        it.query_cid = 16'($urandom);
        return it;
    endfunction

    function automatic result_t mk_res(input outcome_t o, input logic [ADDR_W-1:0] acid,
                                       input logic [ADDR_W-1:0] slot, input logic hit,
                                       input logic dbw, input logic [DB_OFFSET_W-1:0] dbo,
                                       input logic [ADDR_W-1:0] dbv, input logic [15:0] st,
                                       input logic [31:0] rs);
        return {o, acid, slot, hit, dbw, dbo, dbv, st, rs};
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [15:0] cid,
                                    input logic [15:0] st, input logic [31:0] rs,
                                    input logic [15:0] qcid, input bit typed,
                                    input result_t want);
        row_t r;
        r.it = {cmd, cid, st, rs, qcid};
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endfunction

    // sender: bursts of back-to-back words with random gaps between them
    task automatic push_item(input item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_cmd <= it.cmd;
        s_cqe_cid <= it.cqe_cid;
        s_cqe_status <= it.cqe_status;
        s_cqe_result <= it.cqe_result;
        s_query_cid <= it.query_cid;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic walk_plan();
        foreach (plan[i]) begin
            row_typed = plan[i].typed;
            row_want = plan[i].want;
            push_item(plan[i].it);
        end
        row_typed = 1'b0;
        plan.delete();
    endtask

    // drain every awaited word, then let a slow submit finish before touching registers
    task automatic settle();
        s_valid <= 1'b0;
        while (awaited_words.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // one poll: submits, completions for open ids in shuffled order, often a stale entry, queries
    task automatic poll_round();
        int depth, n, k, j;
        logic [ADDR_W-1:0] open_ids[$];
        logic [ADDR_W-1:0] tmp;
        item_t it;
        depth = eff_depth();
        n = $urandom_range(1, (depth < 12) ? depth : 12);
        repeat (n) push_item(junk_item(CMD_SUBMIT));
        for (k = 0; k < depth; k++)
            if (busy_m[k]) open_ids.push_back(ADDR_W'(k));
        for (k = open_ids.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = open_ids[k];
            open_ids[k] = open_ids[j];
            open_ids[j] = tmp;
        end
        n = $urandom_range(0, open_ids.size());
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                // entry for a random id, still in phase
                it = junk_item(CMD_CQE);
                if ($urandom_range(0, 1)) it.cqe_cid = 16'($urandom_range(0, depth - 1));
                it.cqe_status[0] = phase_m;
                push_item(it);
            end
            it = junk_item(CMD_CQE);
            it.cqe_cid = 16'(open_ids[k]);
            it.cqe_status[0] = phase_m;
            push_item(it);
        end
        if ($urandom_range(0, 5) != 0) begin
            it = junk_item(CMD_CQE);
            it.cqe_status[0] = ~phase_m;
            push_item(it);
        end
        repeat ($urandom_range(1, 4)) begin
            it = junk_item($urandom_range(0, 3) != 0 ? CMD_QUERY : CMD_SPARE);
            if ($urandom_range(0, 3) != 0) it.query_cid = 16'($urandom_range(0, depth - 1));
            push_item(it);
        end
    endtask

    initial begin : stimulus
        int ph, first;
        logic [15:0] dv, qv, sv;
        q_depth_reg = DEPTH_RESET;
        q_id_reg = '0;
        q_stride_reg = '0;
        tail_m = '0;
        head_m = '0;
        cid_m = '0;
        phase_m = 1'b1;
        ring_dirty_m = 1'b0;
        inflight_m = '0;
        foreach (busy_m[i]) begin
            busy_m[i] = 1'b0;
            status_m[i] = '0;
            result_m[i] = '0;
        end
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset registers: queries on fresh ids, lone stale entry, first submits and polls
        add_row(CMD_QUERY, 0, 0, 0, 16'd0, 1,
                mk_res(OUT_DONE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_QUERY, 0, 0, 0, 16'd1023, 1,
                mk_res(OUT_DONE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_QUERY, 0, 0, 0, 16'hFFFF, 1,
                mk_res(OUT_NOT_DONE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_SPARE, 0, 0, 0, 16'd5, 1,
                mk_res(OUT_DONE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_CQE, 16'd0, 16'hFFFE, 0, 0, 1,
                mk_res(OUT_STALE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_SUBMIT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1,
                mk_res(OUT_SUBMITTED, 0, 0, 0, 1, DB_BASE, 1, 0, 0));
        add_row(CMD_QUERY, 0, 0, 0, 16'd0, 1,
                mk_res(OUT_NOT_DONE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_SUBMIT, 0, 0, 0, 0, 1,
                mk_res(OUT_SUBMITTED, 1, 1, 0, 1, DB_BASE, 2, 0, 0));
        add_row(CMD_CQE, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 0, 1,
                mk_res(OUT_CONSUMED, 0, 0, 1, 0, 0, 0, 0, 0));
        add_row(CMD_CQE, 16'hFFFF, 16'h0001, 0, 0, 1,
                mk_res(OUT_CONSUMED, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_CQE, 16'd1, 16'h0001, 32'd1, 0, 1,
                mk_res(OUT_CONSUMED, 0, 0, 1, 0, 0, 0, 0, 0));
        add_row(CMD_CQE, 16'd0, 16'h0000, 0, 0, 1,
                mk_res(OUT_STALE, 0, 0, 0, 1, DB_BASE + 35'd4, 3, 0, 0));
        add_row(CMD_CQE, 16'd0, 16'h0000, 0, 0, 1,
                mk_res(OUT_STALE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_QUERY, 0, 0, 0, 16'd0, 1,
                mk_res(OUT_DONE, 0, 0, 0, 0, 0, 0, 16'h7FFF, 32'hFFFF_FFFF));
        add_row(CMD_QUERY, 0, 0, 0, 16'd1, 1,
                mk_res(OUT_DONE, 0, 0, 0, 0, 0, 0, 16'h0000, 32'd1));
        walk_plan();

        // depth field zero (taken as 2), top queue id and stride, upper data bits set
        settle();
        write_reg(CFG_DEPTH, 16'hF800);
        write_reg(CFG_QID, 16'hFFFF);
        write_reg(CFG_STRIDE, 16'hFFFF);
        add_row(CMD_SUBMIT, 0, 0, 0, 0, 0, '0);
        add_row(CMD_SUBMIT, 0, 0, 0, 0, 1,
                mk_res(OUT_FULL, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_CQE, 16'd0, 16'hABCD, 32'h1234_5678, 0, 0, '0);
        add_row(CMD_CQE, 16'd1, 16'h5554, 32'h8765_4321, 0, 0, '0);
        add_row(CMD_CQE, 16'd0, 16'hFFFE, 0, 0, 0, '0);
        add_row(CMD_QUERY, 0, 0, 0, 16'd0, 0, '0);
        add_row(CMD_QUERY, 0, 0, 0, 16'd2, 1,
                mk_res(OUT_NOT_DONE, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(CMD_SPARE, 0, 0, 0, 16'd1, 0, '0);
        walk_plan();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    dv = 16'd1024;
                    qv = 16'd0;
                    sv = 16'd0;
                end
                7: begin
                    dv = 16'h07FF;
                    qv = 16'hFFFF;
                    sv = 16'h000F;
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0: dv = 16'd1;
                        1: dv = 16'd2;
                        2: dv = 16'd3;
                        3: dv = 16'($urandom_range(4, 16));
                        default: dv = 16'($urandom_range(2, 64));
                    endcase
                    qv = 16'($urandom);
                    sv = 16'($urandom);
                end
            endcase
            settle();
            write_reg(CFG_DEPTH, dv);
            write_reg(CFG_QID, qv);
            write_reg(CFG_STRIDE, sv);
            first = items_sent;
            while (items_sent - first < 62) poll_round();
        end

        settle();
        if (awaited_words.size() != 0)
            note_mismatch("words never delivered", awaited_words.size(), 0);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
